/* rtl/tun_pkg.sv */
// Shared constants for the triangle unit normal block.
// No dependencies; used by every module under rtl.
package tun_pkg;

  // Default coordinate width of one vertex component
  localparam int CoordWidthDef    = 16;
  // Default fraction bits of the Q1.F normal components
  localparam int NormalFracBitsDef = 14;

endpackage

/* rtl/tun_cross.sv */
// Edge vectors and cross product, two pipeline stages.
// Depends on tun_pkg for the default coordinate width.
module tun_cross #(
  parameter int COORD_WIDTH = tun_pkg::CoordWidthDef
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [COORD_WIDTH-1:0]   v0_x_i,
  input  logic signed [COORD_WIDTH-1:0]   v0_y_i,
  input  logic signed [COORD_WIDTH-1:0]   v0_z_i,
  input  logic signed [COORD_WIDTH-1:0]   v1_x_i,
  input  logic signed [COORD_WIDTH-1:0]   v1_y_i,
  input  logic signed [COORD_WIDTH-1:0]   v1_z_i,
  input  logic signed [COORD_WIDTH-1:0]   v2_x_i,
  input  logic signed [COORD_WIDTH-1:0]   v2_y_i,
  input  logic signed [COORD_WIDTH-1:0]   v2_z_i,
  output logic signed [2*COORD_WIDTH+2:0] n_x_o,
  output logic signed [2*COORD_WIDTH+2:0] n_y_o,
  output logic signed [2*COORD_WIDTH+2:0] n_z_o
);
  import tun_pkg::*;

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;

  logic signed [EW-1:0] ex1, ey1, ez1, ex2, ey2, ez2;
  logic signed [PW-1:0] pxa_q, pxb_q, pya_q, pyb_q, pza_q, pzb_q;

  // Form edges from the first vertex
  assign ex1 = EW'(v1_x_i) - EW'(v0_x_i);
  assign ey1 = EW'(v1_y_i) - EW'(v0_y_i);
  assign ez1 = EW'(v1_z_i) - EW'(v0_z_i);
  assign ex2 = EW'(v2_x_i) - EW'(v0_x_i);
  assign ey2 = EW'(v2_y_i) - EW'(v0_y_i);
  assign ez2 = EW'(v2_z_i) - EW'(v0_z_i);

  // Register the six products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxa_q <= ey1 * ez2;
      pxb_q <= ez1 * ey2;
      pya_q <= ez1 * ex2;
      pyb_q <= ex1 * ez2;
      pza_q <= ex1 * ey2;
      pzb_q <= ey1 * ex2;
    end
  end

  // Register the cross product components
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_x_o <= (PW+1)'(pxa_q) - (PW+1)'(pxb_q);
      n_y_o <= (PW+1)'(pya_q) - (PW+1)'(pyb_q);
      n_z_o <= (PW+1)'(pza_q) - (PW+1)'(pzb_q);
    end
  end

endmodule

/* rtl/tun_lane.sv */
// One component lane: magnitude square in split partial products, then a
// bit-per-stage exact rounding search of |n| * 2^F / |N|. Depends on tun_pkg.
module tun_lane #(
  parameter int COORD_WIDTH      = tun_pkg::CoordWidthDef,
  parameter int NORMAL_FRAC_BITS = tun_pkg::NormalFracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [2*COORD_WIDTH+2:0] n_i,
  input  logic [4*COORD_WIDTH+3:0]        sum_i,
  output logic [4*COORD_WIDTH+3:0]        sq_o,
  output logic [NORMAL_FRAC_BITS:0]       k_o,
  output logic                            neg_o
);
  import tun_pkg::*;

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NW  = 2 * COORD_WIDTH + 3;
  localparam int AW  = 2 * COORD_WIDTH + 2;
  localparam int SW  = 2 * AW;
  localparam int LO  = AW / 2;
  localparam int HI  = AW - LO;
  localparam int DW  = SW + 2 * F + 4;
  localparam int KW  = F + 1;

  logic signed [NW-1:0] n_abs;
  logic [AW-1:0]        mag;
  logic [2*HI-1:0]      hh_q;
  logic [HI+LO-1:0]     hl_q;
  logic [2*LO-1:0]      ll_q;
  logic                 neg_c_q, neg_d_q, neg_e_q;
  logic [SW-1:0]        sq_q, sq_e_q;

  logic signed [DW-1:0] d_q [F+1];
  logic signed [DW-1:0] p_q [F+1];
  logic signed [DW-1:0] s_q [F+1];
  logic [KW-1:0]        k_q [F+1];
  logic                 done_q [F+1];
  logic                 neg_q [F+1];

  logic signed [DW-1:0] s_ext, x_init;

  // Take the magnitude
  assign n_abs = n_i[NW-1] ? -n_i : n_i;
  assign mag   = n_abs[AW-1:0];

  // Split the square into narrow partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q    <= mag[AW-1:LO] * mag[AW-1:LO];
      hl_q    <= mag[AW-1:LO] * mag[LO-1:0];
      ll_q    <= mag[LO-1:0] * mag[LO-1:0];
      neg_c_q <= n_i[NW-1];
    end
  end

  // Sum the partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q    <= (SW'(hh_q) << (2 * LO)) + (SW'(hl_q) << (LO + 1)) + SW'(ll_q);
      neg_d_q <= neg_c_q;
    end
  end

  assign sq_o = sq_q;

  // Hold the square while the merged sum forms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_e_q  <= sq_q;
      neg_e_q <= neg_d_q;
    end
  end

  // Remainder starts at 4*a^2*2^(2F) minus S, odd multiplier at -1
  assign s_ext  = DW'(sum_i);
  assign x_init = DW'(sq_e_q) <<< (2 * F + 2);

  // One result bit per stage, most significant first
  for (genvar s = 0; s <= F; s++) begin : g_stage
    localparam int B = F - s;
    logic signed [DW-1:0] d_in, p_in, s_in, delta, cand;
    logic [KW-1:0]        k_in;
    logic                 done_in, neg_in, acc;

    if (s == 0) begin : g_first
      assign d_in    = x_init - s_ext;
      assign p_in    = -s_ext;
      assign s_in    = s_ext;
      assign k_in    = '0;
      assign done_in = 1'b0;
      assign neg_in  = neg_e_q;
    end else begin : g_next
      assign d_in    = d_q[s-1];
      assign p_in    = p_q[s-1];
      assign s_in    = s_q[s-1];
      assign k_in    = k_q[s-1];
      assign done_in = done_q[s-1];
      assign neg_in  = neg_q[s-1];
    end

    assign delta = (p_in <<< (B + 2)) + (s_in <<< (2 * B + 2));
    assign cand  = d_in - delta;
    assign acc   = !done_in && !cand[DW-1];

    // Keep the trial bit when the remainder stays non-negative
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s]    <= acc ? cand : d_in;
        p_q[s]    <= acc ? (p_in + (s_in <<< (B + 1))) : p_in;
        k_q[s]    <= acc ? (k_in | (KW'(1) << B)) : k_in;
        done_q[s] <= done_in | (acc && (B == F));
        s_q[s]    <= s_in;
        neg_q[s]  <= neg_in;
      end
    end
  end

  assign k_o   = k_q[F];
  assign neg_o = neg_q[F];

endmodule

/* rtl/triangle_unit_normal.sv */
// Top level of the triangle unit normal block: cross product front end,
// three component lanes and the merging output stage. Depends on tun_pkg.
//
// Accepts one triangle per cycle while in_stall_o is low and returns its unit face
// normal in Q1.F, rounded to nearest (ties away from zero). The pipeline holds the
// edge and cross product registers, the lane squaring and length sum registers,
// one search stage per result bit (F + 1) in each lane, and the output register.
// A zero cross product gives a zero normal with the degenerate flag set. The whole
// pipeline holds while a result is stalled.
module triangle_unit_normal #(
  parameter int COORD_WIDTH      = tun_pkg::CoordWidthDef,
  parameter int NORMAL_FRAC_BITS = tun_pkg::NormalFracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]     v0_x_i,
  input  logic signed [COORD_WIDTH-1:0]     v0_y_i,
  input  logic signed [COORD_WIDTH-1:0]     v0_z_i,
  input  logic signed [COORD_WIDTH-1:0]     v1_x_i,
  input  logic signed [COORD_WIDTH-1:0]     v1_y_i,
  input  logic signed [COORD_WIDTH-1:0]     v1_z_i,
  input  logic signed [COORD_WIDTH-1:0]     v2_x_i,
  input  logic signed [COORD_WIDTH-1:0]     v2_y_i,
  input  logic signed [COORD_WIDTH-1:0]     v2_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_z_o,
  output logic                              degenerate_o
);
  import tun_pkg::*;

  localparam int F  = NORMAL_FRAC_BITS;
  localparam int NW = 2 * COORD_WIDTH + 3;
  localparam int SW = 4 * COORD_WIDTH + 4;
  localparam int OW = F + 2;
  localparam int VL = F + 6;
  localparam int ZL = F + 4;

  logic                 en;
  logic signed [NW-1:0] n_x, n_y, n_z;
  logic [SW-1:0]        sq_x, sq_y, sq_z, sum_q;
  logic [F:0]           k_x, k_y, k_z;
  logic                 neg_x, neg_y, neg_z;
  logic                 vld_q [VL];
  logic                 zero_q [ZL];
  logic                 out_valid_q;

  // Advance everything unless a finished item is stalled
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  tun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk_i  (clk_i),
    .en_i   (en),
    .v0_x_i (v0_x_i), .v0_y_i (v0_y_i), .v0_z_i (v0_z_i),
    .v1_x_i (v1_x_i), .v1_y_i (v1_y_i), .v1_z_i (v1_z_i),
    .v2_x_i (v2_x_i), .v2_y_i (v2_y_i), .v2_z_i (v2_z_i),
    .n_x_o  (n_x),    .n_y_o  (n_y),    .n_z_o  (n_z)
  );

  tun_lane #(.COORD_WIDTH(COORD_WIDTH), .NORMAL_FRAC_BITS(F)) u_lane_x (
    .clk_i (clk_i), .en_i (en), .n_i (n_x), .sum_i (sum_q),
    .sq_o  (sq_x),  .k_o  (k_x), .neg_o (neg_x)
  );

  tun_lane #(.COORD_WIDTH(COORD_WIDTH), .NORMAL_FRAC_BITS(F)) u_lane_y (
    .clk_i (clk_i), .en_i (en), .n_i (n_y), .sum_i (sum_q),
    .sq_o  (sq_y),  .k_o  (k_y), .neg_o (neg_y)
  );

  tun_lane #(.COORD_WIDTH(COORD_WIDTH), .NORMAL_FRAC_BITS(F)) u_lane_z (
    .clk_i (clk_i), .en_i (en), .n_i (n_z), .sum_i (sum_q),
    .sq_o  (sq_z),  .k_o  (k_z), .neg_o (neg_z)
  );

  // Merge the lane squares into the squared length
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sq_x + sq_y + sq_z;
    end
  end

  // Carry the zero flag alongside the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q[0] <= (n_x == '0) && (n_y == '0) && (n_z == '0);
      for (int i = 1; i < ZL; i++) begin
        zero_q[i] <= zero_q[i-1];
      end
    end
  end

  // Track item valid through the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VL; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < VL; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_valid_q <= vld_q[VL-1];
    end
  end

  // Apply signs, force zero on a degenerate triangle
  always_ff @(posedge clk_i) begin
    if (en) begin
      degenerate_o <= zero_q[ZL-1];
      if (zero_q[ZL-1]) begin
        normal_x_o <= '0;
        normal_y_o <= '0;
        normal_z_o <= '0;
      end else begin
        normal_x_o <= neg_x ? -OW'(k_x) : OW'(k_x);
        normal_y_o <= neg_y ? -OW'(k_y) : OW'(k_y);
        normal_z_o <= neg_z ? -OW'(k_z) : OW'(k_z);
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* tb/triangle_unit_normal_tb.sv */
// Self-checking testbench for triangle_unit_normal: streams triangles under random
// bursts and output stalls, checks each unit normal against an exact in-bench predictor.
// Depends on tun_pkg and the triangle_unit_normal RTL.
module triangle_unit_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = tun_pkg::CoordWidthDef;
  localparam int FB = tun_pkg::NormalFracBitsDef;
  localparam int OW = FB + 2;
  localparam int LATENCY = FB + 7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_RANDOM = 480;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t v[9];      // v0 xyz, v1 xyz, v2 xyz
    bit     drain;     // marker: hold the sender until all normals are back
  } tri_t;

  typedef struct {
    logic signed [OW-1:0] nx, ny, nz;
    logic                 degen;
  } normal_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  coord_t v_drv[9];
  logic signed [OW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;

  tri_t    tri_q[$];
  normal_t normal_q[$];
  int      cycles, errors, n_checked, n_degen, n_axis, n_sent;
  bit      took_item;
  bit      long_hold_done;
  int      hold_left;

  triangle_unit_normal dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .v0_x_i(v_drv[0]), .v0_y_i(v_drv[1]), .v0_z_i(v_drv[2]),
    .v1_x_i(v_drv[3]), .v1_y_i(v_drv[4]), .v1_z_i(v_drv[5]),
    .v2_x_i(v_drv[6]), .v2_y_i(v_drv[7]), .v2_z_i(v_drv[8]),
    .out_valid_o, .out_stall_i, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  // Largest k in [0, 2^FB] with 4*a^2*2^(2FB) >= (2k-1)^2 * len2
  function automatic longint round_mag(logic [37:0] a, logic [159:0] len2);
    logic [159:0] lhs, rhs;
    longint lo, hi, mid, odd;
    lhs = (160'(a) * 160'(a)) << (2 * FB + 2);
    lo = 0;
    hi = longint'(1) << FB;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      odd = 2 * mid - 1;
      rhs = 160'(odd * odd) * len2;
      if (lhs >= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Exact face normal: edges, cross product, length and rounded components
  function automatic normal_t face_normal(tri_t t);
    logic signed [CW+1:0] e1[3], e2[3];
    logic signed [37:0] cr[3];
    logic [37:0] m[3];
    logic [159:0] len2;
    longint q;
    normal_t r;
    logic signed [OW-1:0] comp[3];
    for (int i = 0; i < 3; i++) begin
      e1[i] = t.v[3+i] - t.v[i];
      e2[i] = t.v[6+i] - t.v[i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    r.degen = (cr[0] == 0 && cr[1] == 0 && cr[2] == 0);
    len2 = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = cr[i] < 0 ? 38'(-cr[i]) : 38'(cr[i]);
      len2 += 160'(m[i]) * 160'(m[i]);
    end
    for (int i = 0; i < 3; i++) begin
      q = r.degen ? 0 : round_mag(m[i], len2);
      comp[i] = cr[i] < 0 ? OW'(-q) : OW'(q);
    end
    r.nx = comp[0];
    r.ny = comp[1];
    r.nz = comp[2];
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom_range(0, 65535));
      1: return coord_t'($signed($urandom_range(0, 16)) - 8);
      default: return ($urandom_range(0, 1)) ? coord_t'(16'h7fff - $urandom_range(0, 3))
                                             : coord_t'(16'h8000 + $urandom_range(0, 3));
    endcase
  endfunction

  task automatic add_tri(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_t t;
    t.drain = 0;
    t.v = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0), coord_t'(b1),
            coord_t'(b2), coord_t'(c0), coord_t'(c1), coord_t'(c2)};
    tri_q = {tri_q, t};
  endtask

  task automatic add_drain();
    tri_t t;
    t.drain = 1;
    foreach (t.v[i]) t.v[i] = '0;
    tri_q = {tri_q, t};
  endtask

  // Clock and cycle limit
  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d normals outstanding", $time, normal_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: record accepted triangles, check accepted normals
  always @(posedge clk_i) begin
    normal_t exp_n;
    took_item = 0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      tri_t t;
      took_item = 1;
      foreach (t.v[i]) t.v[i] = v_drv[i];
      normal_q = {normal_q, face_normal(t)};
      n_sent++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (normal_q.size() == 0) begin
        $display("%0t: unexpected normal %0d %0d %0d deg %0b", $time,
                 normal_x_o, normal_y_o, normal_z_o, degenerate_o);
        errors++;
      end else begin
        exp_n = normal_q.pop_front();
        n_checked++;
        if (exp_n.degen) n_degen++;
        if (exp_n.nx == 0 && exp_n.ny == 0 && !exp_n.degen) n_axis++;
        if (normal_x_o !== exp_n.nx || normal_y_o !== exp_n.ny ||
            normal_z_o !== exp_n.nz || degenerate_o !== exp_n.degen) begin
          $display("%0t: mismatch expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                   $time, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degen,
                   normal_x_o, normal_y_o, normal_z_o, degenerate_o);
          errors++;
        end
      end
    end
  end

  // Driver: bursts of triangles with random gaps; drain markers hold until empty
  int burst_left, gap_left;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took_item)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 0;
      end else if (tri_q.size() > 0 && tri_q[0].drain) begin
        in_valid_i <= 0;
        if (normal_q.size() == 0) void'(tri_q.pop_front());
      end else if (tri_q.size() > 0) begin
        in_valid_i <= 1;
        for (int i = 0; i < 9; i++) v_drv[i] <= tri_q[0].v[i];
        void'(tri_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 0;
      end
    end
  end

  // Receiver: stall pattern changes every so often; one long hold fills the pipe
  int mode, mode_left;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && n_sent > 150) begin
        long_hold_done <= 1;
        hold_left <= 200;
        out_stall_i <= 1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1;
      end else begin
        if (mode_left == 0) begin
          mode <= $urandom_range(0, 3);
          mode_left <= $urandom_range(20, 120);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (mode)
          0: out_stall_i <= 0;
          1: out_stall_i <= ($urandom_range(0, 1) == 0);
          2: out_stall_i <= ($urandom_range(0, 7) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int m;
    tri_t t;
    rst_ni = 0;
    in_valid_i = 0;
    out_stall_i = 0;
    foreach (v_drv[i]) v_drv[i] = '0;
    cycles = 0; errors = 0; n_checked = 0; n_degen = 0; n_axis = 0; n_sent = 0;
    took_item = 0; long_hold_done = 0; hold_left = 0;
    burst_left = 8; gap_left = 0; mode = 0; mode_left = 30;

    // Directed: zero and collinear triangles, axis normals, extreme coordinates
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(1, 2, 3, 2, 4, 6, 3, 6, 9);
    add_tri(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0);
    add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_tri(0, 0, 0, 0, 1, 0, 1, 0, 0);
    add_tri(0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_tri(0, 0, 0, 0, 0, 1, 1, 0, 0);
    add_tri(5, 5, 5, 5, 5, 5, 9, -3, 2);
    add_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
    add_tri(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767);
    add_tri(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768);
    add_tri(32767, -32768, 32767, -32768, 32767, 32767, -32768, -32768, -32768);
    add_tri(-32768, -32768, 0, 32767, 32767, 0, -32768, 32767, 0);
    add_tri(0, 0, 0, 1, 1, 0, 1, 0, 1);
    add_tri(0, 0, 0, 3, 0, 0, 0, 4, 12);
    add_tri(0, 0, 0, 1, 1, 1, -1, 1, 0);
    add_tri(-1, -1, -1, 0, 0, 0, 0, 0, 0);
    add_tri(100, -200, 300, 100, -200, 301, 100, -199, 300);
    add_tri(32767, 0, 0, -32768, 0, 0, 0, 0, 0);
    add_drain();

    // Random: full range, small values, near-extremes, repeated vertices, flat planes
    for (int k = 0; k < NUM_RANDOM; k++) begin
      m = $urandom_range(0, 9);
      t.drain = 0;
      for (int i = 0; i < 9; i++)
        t.v[i] = rand_coord(m < 5 ? 0 : (m < 8 ? 1 : 2));
      if ($urandom_range(0, 9) == 0) begin
        // collapse one vertex onto another
        int vi;
        vi = 3 * $urandom_range(1, 2);
        for (int i = 0; i < 3; i++) t.v[vi + i] = t.v[i];
      end else if ($urandom_range(0, 9) == 0) begin
        // flat in one axis plane
        int ax;
        ax = $urandom_range(0, 2);
        t.v[3 + ax] = t.v[ax];
        t.v[6 + ax] = t.v[ax];
      end
      tri_q = {tri_q, t};
      if (k == 240) add_drain();
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;

    wait (tri_q.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || normal_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Checked %0d normals (%0d degenerate, %0d along z) from %0d triangles",
             n_checked, n_degen, n_axis, n_sent);
    $display("Included a long output hold, sender drains and random stall patterns");
    if (errors == 0 && normal_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tun_pkg.sv
rtl/tun_cross.sv
rtl/tun_lane.sv
rtl/triangle_unit_normal.sv
tb/triangle_unit_normal_tb.sv
